// File: rtl/cot_pkg.sv
// Shared types and constants for the cell owner change tracker.
// No dependencies; used by the front end, the back end and the top level of the block.
package cot_pkg;

  // Item field widths, fixed by the stream format
  localparam int OWNER_W  = 8;
  localparam int ADDR_W   = 13;
  localparam int RUNLEN_W = 13;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // Owner value of a cell nobody has claimed
  localparam logic [OWNER_W-1:0] UNOWNED = 8'hFF;

  // Changed flags are stored as words of this many cells
  localparam int FLAG_W  = 32;
  localparam int FLAG_SH = 5;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // Item operation codes, also used as command kind
  typedef enum logic {
    CMD_MARK  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_kind_t;

endpackage

// File: rtl/cot_front.sv
// Front end: accepts items, drops ignored marks, normalizes run lengths
// and pushes commands into the queue. Depends on cot_pkg.
module cot_front
  import cot_pkg::*;
#(
  parameter int ARENA_CELLS = 6144,
  parameter int CMD_W       = 32
) (
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // run_mode, owner, address, address_valid,
                                           // run_length, to_register, zero pad
  input  logic                 in_tuser,   // operation
  // command queue push side
  input  logic                 init_done,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [CMD_W-1:0]     q_data
);

  localparam int IW = $clog2(ARENA_CELLS);
  localparam int LW = $clog2(ARENA_CELLS + 1);

  typedef logic [IW-1:0] cell_t;
  typedef logic [LW-1:0] len_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [OWNER_W-1:0]   owner;
    cell_t                first_cell;
    len_t                 len;
  } cmd_t;

  // Item fields
  logic                run_mode;
  logic [OWNER_W-1:0]  owner;
  logic [ADDR_W-1:0]   address;
  logic                address_valid;
  logic [RUNLEN_W-1:0] run_length;
  logic                to_register;

  assign run_mode      = in_tdata[0];
  assign owner         = in_tdata[8:1];
  assign address       = in_tdata[21:9];
  assign address_valid = in_tdata[22];
  assign run_length    = in_tdata[35:23];
  assign to_register   = in_tdata[36];

  logic is_drain;
  logic mark_ok;
  logic len_sat;
  cmd_t cmd;

  // Classification: a drain always goes through, a mark only when it touches a cell
  always_comb begin
    is_drain = (in_tuser == CMD_DRAIN);
    len_sat  = (32'(run_length) > 32'(ARENA_CELLS));
    mark_ok  = address_valid && !to_register &&
               (32'(address) < 32'(ARENA_CELLS)) &&
               (!run_mode || (run_length != '0));
    cmd.kind       = is_drain ? CMD_DRAIN : CMD_MARK;
    cmd.owner      = owner;
    cmd.first_cell = cell_t'(address);
    if (!run_mode) begin
      cmd.len = len_t'(1);
    end else if (len_sat) begin
      cmd.len = len_t'(ARENA_CELLS);
    end else begin
      cmd.len = len_t'(run_length);
    end
  end

  // No item is taken before the clearing pass is over
  assign in_tready = init_done && !q_full && rst_n;
  assign q_push    = in_tvalid && in_tready && (is_drain || mark_ok);
  assign q_data    = cmd;

endmodule

// File: rtl/cot_queue.sv
// Small command queue between front and back ends.
// No package dependencies; register-based storage.
module cot_queue #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + CW'(1);
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/cot_back.sv
// Back end: clears the tables after reset, executes marks cell by cell and
// drains by scanning flag words. Holds the owner and flag memories and the
// result register. Depends on cot_pkg.
module cot_back
  import cot_pkg::*;
#(
  parameter int ARENA_CELLS = 6144,
  parameter int CMD_W       = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command queue pop side
  input  logic [CMD_W-1:0]      q_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  init_done,
  // result item channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cell_address, cell_owner, zero pad
  output logic                  out_tuser   // found
);

  localparam int IW    = $clog2(ARENA_CELLS);
  localparam int LW    = $clog2(ARENA_CELLS + 1);
  localparam int NROWS = (ARENA_CELLS + FLAG_W - 1) / FLAG_W;
  localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int SW    = $clog2(NROWS * FLAG_W + 1);

  typedef logic [IW-1:0]      cell_t;
  typedef logic [LW-1:0]      len_t;
  typedef logic [RW-1:0]      row_t;
  typedef logic [SW-1:0]      scan_t;
  typedef logic [FLAG_SH-1:0] bit_t;
  typedef logic [FLAG_W-1:0]  flag_word_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [OWNER_W-1:0]   owner;
    cell_t                first_cell;
    len_t                 len;
  } cmd_t;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_MK_RD   = 7'b0000100,
    ST_MK_WR   = 7'b0001000,
    ST_DR_SCAN = 7'b0010000,
    ST_DR_EVAL = 7'b0100000,
    ST_DR_OUT  = 7'b1000000
  } state_t;

  // Lowest set bit of a flag word
  function automatic bit_t lowest_set(input flag_word_t w);
    bit_t r;
    r = '0;
    for (int i = FLAG_W - 1; i >= 0; i--) begin
      if (w[i]) r = bit_t'(i);
    end
    return r;
  endfunction

  cmd_t head;
  assign head = cmd_t'(q_data);

  // Control and working registers
  state_t     state_r,  state_nxt;
  cell_t      cnt_r,    cnt_nxt;
  cmd_t       cmd_r,    cmd_nxt;
  cell_t      pos_r,    pos_nxt;
  len_t       rem_r,    rem_nxt;
  scan_t      scan_r,   scan_nxt;
  scan_t      cursor_r, cursor_nxt;
  cell_t      hit_r,    hit_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [ADDR_W-1:0]   out_addr_r,  out_addr_nxt;
  logic [OWNER_W-1:0]  out_owner_r, out_owner_nxt;

  // Memories and their port controls
  logic [OWNER_W-1:0] owner_mem [ARENA_CELLS];
  flag_word_t         flag_mem  [NROWS];
  logic [OWNER_W-1:0] owner_q;
  flag_word_t         flag_q;

  logic               own_re, own_we;
  cell_t              own_ra, own_wa;
  logic [OWNER_W-1:0] own_wd;
  logic               flg_re, flg_we;
  row_t               flg_ra, flg_wa;
  flag_word_t         flg_wd;

  logic       out_free;
  row_t       pos_row;
  bit_t       pos_bit;
  row_t       scan_row;
  bit_t       scan_bit;
  flag_word_t masked;
  bit_t       hit_bit;
  cell_t      hit_cell;

  always_comb begin
    out_free = !out_valid_r || out_tready;
    pos_row  = row_t'(pos_r >> FLAG_SH);
    pos_bit  = bit_t'(pos_r);
    scan_row = row_t'(scan_r >> FLAG_SH);
    scan_bit = bit_t'(scan_r);
    masked   = flag_q & ({FLAG_W{1'b1}} << scan_bit);
    hit_bit  = lowest_set(masked);
    hit_cell = cell_t'({scan_row, hit_bit});
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    scan_nxt   = scan_r;
    cursor_nxt = cursor_r;
    hit_nxt    = hit_r;
    q_pop      = 1'b0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    out_owner_nxt = out_owner_r;

    own_re = 1'b0;
    own_ra = pos_r;
    own_we = 1'b0;
    own_wa = pos_r;
    own_wd = cmd_r.owner;
    flg_re = 1'b0;
    flg_ra = pos_row;
    flg_we = 1'b0;
    flg_wa = pos_row;
    flg_wd = flag_q | (flag_word_t'(1) << pos_bit);

    unique case (state_r)
      // Clearing pass: one owner entry a cycle, flag rows along the way
      ST_CLEAR: begin
        own_we = 1'b1;
        own_wa = cnt_r;
        own_wd = UNOWNED;
        flg_we = 1'b1;
        flg_wa = row_t'(cnt_r >> FLAG_SH);
        flg_wd = '0;
        cnt_nxt = cnt_r + cell_t'(1);
        if (cnt_r == cell_t'(ARENA_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = head;
          pos_nxt = head.first_cell;
          rem_nxt = head.len;
          scan_nxt = cursor_r;
          state_nxt = (head.kind == CMD_DRAIN) ? ST_DR_SCAN : ST_MK_RD;
        end
      end

      // Mark: read the cell's owner and its flag word
      ST_MK_RD: begin
        own_re = 1'b1;
        flg_re = 1'b1;
        state_nxt = ST_MK_WR;
      end

      // Mark: write back only when the owner really changes
      ST_MK_WR: begin
        if (owner_q != cmd_r.owner) begin
          own_we = 1'b1;
          flg_we = 1'b1;
        end
        pos_nxt = (pos_r == cell_t'(ARENA_CELLS - 1)) ? '0 : pos_r + cell_t'(1);
        rem_nxt = rem_r - len_t'(1);
        state_nxt = (rem_r == len_t'(1)) ? ST_IDLE : ST_MK_RD;
      end

      // Drain: fetch the next flag row, or finish with nothing found
      ST_DR_SCAN: begin
        if (scan_r >= scan_t'(ARENA_CELLS)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_addr_nxt  = '0;
            out_owner_nxt = '0;
            cursor_nxt    = '0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          flg_re = 1'b1;
          flg_ra = scan_row;
          state_nxt = ST_DR_EVAL;
        end
      end

      // Drain: first changed cell at or after scan_r: clear it, fetch its owner
      ST_DR_EVAL: begin
        if (masked != '0) begin
          flg_we  = 1'b1;
          flg_wa  = scan_row;
          flg_wd  = flag_q & ~(flag_word_t'(1) << hit_bit);
          own_re  = 1'b1;
          own_ra  = hit_cell;
          hit_nxt = hit_cell;
          state_nxt = ST_DR_OUT;
        end else begin
          scan_nxt  = scan_t'(((scan_r >> FLAG_SH) + scan_t'(1)) << FLAG_SH);
          state_nxt = ST_DR_SCAN;
        end
      end

      ST_DR_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_addr_nxt  = ADDR_W'(hit_r);
          out_owner_nxt = owner_q;
          cursor_nxt    = scan_t'(hit_r) + scan_t'(1);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    pos_r       <= pos_nxt;
    rem_r       <= rem_nxt;
    scan_r      <= scan_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
    out_owner_r <= out_owner_nxt;
  end

  // Owner memory
  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[own_wa] <= own_wd;
    end
    if (own_re) begin
      owner_q <= owner_mem[own_ra];
    end
  end

  // Changed flag memory, one word per row of cells
  always_ff @(posedge clk) begin
    if (flg_we) begin
      flag_mem[flg_wa] <= flg_wd;
    end
    if (flg_re) begin
      flag_q <= flag_mem[flg_ra];
    end
  end

  assign init_done  = (state_r != ST_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_DATA_W'({out_owner_r, out_addr_r});

endmodule

// File: rtl/cell_owner_change_tracker.sv
// Top level of the cell owner change tracker.
// Depends on cot_pkg, cot_front, cot_queue and cot_back.
//
// Channel   Dir  tdata (low bit up)                               tuser
// in_*      in   run_mode, owner, address, address_valid,         operation
//                run_length, to_register, pad to 40 bits
// out_*     out  cell_address, cell_owner, pad to 24 bits         found
//
// After reset a clearing pass sets every owner to unowned and clears the changed
// flags; in_tready stays low until it ends.
// A mark leaves the queue, then each cell it touches is read and, on an owner change,
// written back; ignored marks never reach the back end.
// A drain checks 32-cell flag rows in turn and reads the owner of the first changed cell.
// A 4-entry command queue lets items come in while the back end works;
// a full queue or a held result register stalls the corresponding side.
module cell_owner_change_tracker
  import cot_pkg::*;
#(
  parameter int ARENA_CELLS = 6144
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // run_mode, owner, address, address_valid,
                                            // run_length, to_register, zero pad
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cell_address, cell_owner, zero pad
  output logic                  out_tuser   // found
);

  localparam int IW    = $clog2(ARENA_CELLS);
  localparam int LW    = $clog2(ARENA_CELLS + 1);
  localparam int CMD_W = 1 + OWNER_W + IW + LW;

  logic             q_push;
  logic [CMD_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic [CMD_W-1:0] q_pop_data;
  logic             q_empty;
  logic             init_done;

  cot_front #(
    .ARENA_CELLS (ARENA_CELLS),
    .CMD_W       (CMD_W)
  ) u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  cot_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  cot_back #(
    .ARENA_CELLS (ARENA_CELLS),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_pop_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/cot_checker.sv
// Scoreboard for the cell owner change tracker: watches both streams, keeps its own
// owner and changed-flag tables, predicts each drain result and compares it.
// Depends on cot_pkg.
`timescale 1ns / 1ps

module cot_checker
  import cot_pkg::*;
#(
  parameter int ARENA_CELLS = 6144
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    fail_count,
  output int                    pending
);

  // Input item layout, MSB first
  typedef struct packed {
    logic [2:0]          pad;
    logic                to_reg;
    logic [RUNLEN_W-1:0] len;
    logic                addr_ok;
    logic [ADDR_W-1:0]   addr;
    logic [OWNER_W-1:0]  who;
    logic                run;
  } mark_fields_t;

  typedef struct packed {
    logic               found;
    logic [ADDR_W-1:0]  addr;
    logic [OWNER_W-1:0] owner;
  } cell_report_t;

  logic [OWNER_W-1:0] owner_map [ARENA_CELLS];
  bit                 changed_map [ARENA_CELLS];
  int                 scan_pos;
  cell_report_t       pending_reports [$];
  int                 fails;

  // Flag is raised only on a real owner change
  function automatic void record_owner(int idx, logic [OWNER_W-1:0] who);
    if (owner_map[idx] != who) begin
      owner_map[idx]   = who;
      changed_map[idx] = 1'b1;
    end
  endfunction

  function automatic void apply_mark(mark_fields_t m);
    int count;
    int pos;
    if (!m.addr_ok || m.to_reg || m.addr >= ARENA_CELLS) return;
    if (!m.run) begin
      record_owner(m.addr, m.who);
      return;
    end
    // laps beyond one full arena change nothing more
    count = (m.len > ARENA_CELLS) ? ARENA_CELLS : m.len;
    pos   = m.addr;
    repeat (count) begin
      record_owner(pos, m.who);
      pos = (pos == ARENA_CELLS - 1) ? 0 : pos + 1;
    end
  endfunction

  // Next changed cell at or after the cursor; none found rewinds the cursor
  function automatic cell_report_t drain_next();
    cell_report_t rep;
    rep = '0;
    for (int i = scan_pos; i < ARENA_CELLS; i++) begin
      if (changed_map[i]) begin
        changed_map[i] = 1'b0;
        scan_pos       = i + 1;
        rep.found      = 1'b1;
        rep.addr       = ADDR_W'(i);
        rep.owner      = owner_map[i];
        return rep;
      end
    end
    scan_pos = 0;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : track
    cell_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < ARENA_CELLS; i++) begin
        owner_map[i]   = UNOWNED;
        changed_map[i] = 1'b0;
      end
      scan_pos = 0;
      fails    = 0;
      pending_reports.delete();
    end else begin
      // accepted input item
      if (in_tvalid && in_tready) begin
        if (cmd_kind_t'(in_tuser) == CMD_DRAIN) begin
          want            = drain_next();
          pending_reports = {pending_reports, want};
        end else begin
          apply_mark(mark_fields_t'(in_tdata));
        end
      end
      // accepted result item
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, actual found=%0b cell_address=%0d cell_owner=%0d",
                   $time, out_tuser, out_tdata[ADDR_W-1:0],
                   out_tdata[ADDR_W +: OWNER_W]);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          check_field("found", 16'(want.found), 16'(out_tuser));
          check_field("cell_address", 16'(want.addr), 16'(out_tdata[ADDR_W-1:0]));
          check_field("cell_owner", 16'(want.owner), 16'(out_tdata[ADDR_W +: OWNER_W]));
        end
      end
    end
    fail_count <= fails;
    pending    <= pending_reports.size();
  end

endmodule

// File: tb/cell_owner_change_tracker_tb.sv
// Top of the cell owner change tracker testbench: clock, reset, stimulus, result
// backpressure, watchdog and verdict. Depends on cot_pkg, cot_checker and the block.
`timescale 1ns / 1ps

module cell_owner_change_tracker_tb;
  import cot_pkg::*;

  localparam int ARENA_CELLS = 6144;
  localparam int N_ITEMS     = 1700;
  localparam int WINDOW      = 32;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT  = 200000;
  localparam int END_WAIT    = 2 * ARENA_CELLS + 500;
  localparam int MAX_GAP     = 11;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;

  // no-idle stretches on each side
  bit                    in_calm  = 1'b0;
  bit                    out_calm = 1'b0;

  // current hot window of the arena and the owners fighting over it
  int                    win_base;
  logic [OWNER_W-1:0]    owner_pool [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_owner_change_tracker #(
    .ARENA_CELLS(ARENA_CELLS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  cot_checker #(
    .ARENA_CELLS(ARENA_CELLS)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Offer one item after a random gap; returns at the falling edge after acceptance
  task automatic send_item(input cmd_kind_t kind, input logic run,
                           input logic [OWNER_W-1:0] who, input logic [ADDR_W-1:0] addr,
                           input logic addr_ok, input logic [RUNLEN_W-1:0] len,
                           input logic to_reg);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, to_reg, len, addr_ok, addr, who, run};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 99) == 0) in_calm = !in_calm;
  endtask

  // Drain with random values in the fields a drain ignores
  task automatic send_drain();
    send_item(CMD_DRAIN, 1'($urandom), OWNER_W'($urandom), ADDR_W'($urandom),
              1'($urandom), RUNLEN_W'($urandom), 1'($urandom));
  endtask

  task automatic new_phase();
    if ($urandom_range(0, 9) < 3) begin
      win_base = $urandom_range(ARENA_CELLS - 20, ARENA_CELLS - 1);
    end else begin
      win_base = $urandom_range(0, ARENA_CELLS - 1);
    end
    for (int k = 0; k < 3; k++) owner_pool[k] = OWNER_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) owner_pool[2] = UNOWNED;
  endtask

  // Mostly drains and window marks; a few long runs and ignored marks
  task automatic random_item(output bit useful);
    int pick;
    logic [ADDR_W-1:0] addr;
    logic addr_ok;
    logic to_reg;
    pick   = $urandom_range(0, 999);
    useful = 1'b1;
    if (pick < 430) begin
      send_drain();
    end else if (pick < 880) begin
      addr = ADDR_W'((win_base + $urandom_range(0, WINDOW - 1)) % ARENA_CELLS);
      send_item(CMD_MARK, 1'($urandom), owner_pool[$urandom_range(0, 2)], addr, 1'b1,
                RUNLEN_W'($urandom_range(0, 12)), 1'b0);
    end else if (pick < 883) begin
      // long run back to unowned; most of the arena is unowned already
      send_item(CMD_MARK, 1'b1, UNOWNED, ADDR_W'($urandom_range(0, ARENA_CELLS - 1)), 1'b1,
                RUNLEN_W'($urandom_range(1000, 8191)), 1'b0);
    end else begin
      useful  = 1'b0;
      addr    = ADDR_W'($urandom_range(0, ARENA_CELLS - 1));
      addr_ok = 1'b1;
      to_reg  = 1'b0;
      if (pick < 920) begin
        addr = ADDR_W'($urandom_range(ARENA_CELLS, 8191));
      end else if (pick < 960) begin
        addr_ok = 1'b0;
      end else begin
        to_reg = 1'b1;
      end
      send_item(CMD_MARK, 1'($urandom), OWNER_W'($urandom), addr, addr_ok,
                RUNLEN_W'($urandom), to_reg);
    end
    if ($urandom_range(0, 79) == 0) new_phase();
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int  useful_items;
    bit  useful;
    useful_items = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty drain, field extremes, ignored marks, wrap, zero and saturated runs
    send_item(CMD_DRAIN, 1'b1, 8'hFF, 13'h1FFF, 1'b1, 13'h1FFF, 1'b1);
    send_item(CMD_MARK, 1'b1, UNOWNED, 13'd4000, 1'b1, 13'h1FFF, 1'b0);
    send_item(CMD_MARK, 1'b0, 8'd0, 13'd0, 1'b1, 13'd0, 1'b0);
    send_item(CMD_MARK, 1'b0, 8'd254, 13'(ARENA_CELLS - 1), 1'b1, 13'd0, 1'b0);
    send_item(CMD_MARK, 1'b0, UNOWNED, 13'd100, 1'b1, 13'd0, 1'b0);
    send_item(CMD_MARK, 1'b0, 8'd1, 13'(ARENA_CELLS), 1'b1, 13'd0, 1'b0);
    send_item(CMD_MARK, 1'b1, 8'd2, 13'h1FFF, 1'b1, 13'd5, 1'b0);
    send_item(CMD_MARK, 1'b0, 8'd3, 13'd5, 1'b0, 13'd0, 1'b0);
    send_item(CMD_MARK, 1'b1, 8'd4, 13'd6, 1'b1, 13'd3, 1'b1);
    send_item(CMD_MARK, 1'b1, 8'd7, 13'(ARENA_CELLS - 4), 1'b1, 13'd8, 1'b0);
    send_item(CMD_MARK, 1'b1, 8'd9, 13'd50, 1'b1, 13'd0, 1'b0);
    send_item(CMD_MARK, 1'b0, 8'd7, 13'd0, 1'b1, 13'd0, 1'b0);
    repeat (9) send_drain();
    // same owner again after draining: no flag
    send_item(CMD_MARK, 1'b0, 8'd7, 13'd2, 1'b1, 13'd0, 1'b0);
    send_item(CMD_DRAIN, 1'b0, 8'h00, 13'h0000, 1'b0, 13'h0000, 1'b0);

    // random part
    new_phase();
    while (useful_items < N_ITEMS) begin
      random_item(useful);
      if (useful) useful_items++;
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (END_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random ready gaps, two long hold-offs to back up the block
  initial begin : receiver
    int results;
    int wait_n;
    results = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      wait_n = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (results == 30 || results == 400) wait_n = HOLD_CYCLES;
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results++;
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: sim.f
rtl/cot_pkg.sv
rtl/cot_front.sv
rtl/cot_queue.sv
rtl/cot_back.sv
rtl/cell_owner_change_tracker.sv
tb/cot_checker.sv
tb/cell_owner_change_tracker_tb.sv
